// ----- rtl/tpa_pkg.sv -----
// Shared constants, payload types and controller/datapath command types.
package tpa_pkg;

	localparam int NEIGHBOURS_PER_SIDE = 4;
	localparam int MAX_NEIGH = 2 * NEIGHBOURS_PER_SIDE;
	localparam int NUM_CHAN = 3;
	localparam int PIX_W = 8;
	// Counts reach MAX_NEIGH + 1 samples.
	localparam int CNT_W = $clog2(MAX_NEIGH + 2);
	localparam int SUM_W = $clog2(((1 << PIX_W) - 1) * (MAX_NEIGH + 1) + 1);
	localparam int SEEN_W = $clog2(MAX_NEIGH + 1);
	localparam int STEP_W = $clog2(SUM_W);

	localparam logic [PIX_W-1:0] TAU_RESET = PIX_W'(20);
	localparam logic KIND_REF = 1'b0;
	localparam logic KIND_NEIGH = 1'b1;

	typedef logic [NUM_CHAN-1:0][PIX_W-1:0] pix_vec_t;

	typedef struct packed {
		logic acc_en;
		logic div_load;
		logic div_step;
		logic res_load;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
	} dp_sts_t;

endpackage

// ----- rtl/tpa_in_if.sv -----
// Input stream interface: one pixel sample per transaction.
interface tpa_in_if;
	logic valid;
	logic ready;
	logic kind;
	logic [tpa_pkg::PIX_W-1:0] chan_red;
	logic [tpa_pkg::PIX_W-1:0] chan_green;
	logic [tpa_pkg::PIX_W-1:0] chan_blue;
	logic last;

	modport source (output valid, kind, chan_red, chan_green, chan_blue, last, input ready);
	modport sink (input valid, kind, chan_red, chan_green, chan_blue, last, output ready);
endinterface

// ----- rtl/tpa_out_if.sv -----
// Output stream interface: one denoised pixel per transaction.
interface tpa_out_if;
	logic valid;
	logic ready;
	logic [tpa_pkg::PIX_W-1:0] out_red;
	logic [tpa_pkg::PIX_W-1:0] out_green;
	logic [tpa_pkg::PIX_W-1:0] out_blue;

	modport source (output valid, out_red, out_green, out_blue, input ready);
	modport sink (input valid, out_red, out_green, out_blue, output ready);
endinterface

// ----- rtl/tpa_ctrl.sv -----
// Controller: sequences accumulation, the bit-serial divide and the result register.
module tpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_last,
	output logic              in_ready,
	input  logic              out_ready,
	output logic              out_valid,
	output tpa_pkg::dp_cmd_t  cmd,
	input  tpa_pkg::dp_sts_t  sts
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} ctl_state_t;

	ctl_state_t state_q;
	ctl_state_t state_d;
	logic out_valid_q;
	logic accept;
	logic res_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	// The result register is free when empty or drained in this cycle.
	assign res_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd.acc_en = 1'b0;
		cmd.div_load = 1'b0;
		cmd.div_step = 1'b0;
		cmd.res_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.acc_en = 1'b1;
					if (in_last) begin
						cmd.div_load = 1'b1;
						state_d = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (res_free) begin
					cmd.res_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- rtl/tpa_dp.sv -----
// Datapath: per-channel thresholded accumulation, bit-serial divider and rounding.
module tpa_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [tpa_pkg::PIX_W-1:0]   cfg_wdata,
	input  logic                        kind,
	input  tpa_pkg::pix_vec_t           px,
	input  tpa_pkg::dp_cmd_t            cmd,
	output tpa_pkg::dp_sts_t            sts,
	output tpa_pkg::pix_vec_t           res
);

	logic [tpa_pkg::PIX_W-1:0] tau_q;
	logic [tpa_pkg::SEEN_W-1:0] seen_q;
	logic [tpa_pkg::STEP_W-1:0] step_q;
	logic take;

	// A neighbour is only considered while under the per-pixel limit.
	assign take = (kind == tpa_pkg::KIND_NEIGH) &&
		(seen_q < tpa_pkg::SEEN_W'(tpa_pkg::MAX_NEIGH));
	assign sts.div_done = (step_q == tpa_pkg::STEP_W'(tpa_pkg::SUM_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tau_q <= tpa_pkg::TAU_RESET;
			seen_q <= '0;
			step_q <= '0;
		end else begin
			if (cfg_we) begin
				tau_q <= cfg_wdata;
			end
			if (cmd.acc_en) begin
				if (kind == tpa_pkg::KIND_REF) begin
					seen_q <= '0;
				end else if (take) begin
					seen_q <= seen_q + tpa_pkg::SEEN_W'(1);
				end
			end
			if (cmd.div_load) begin
				step_q <= '0;
			end else if (cmd.div_step) begin
				step_q <= step_q + tpa_pkg::STEP_W'(1);
			end
		end
	end

	for (genvar c = 0; c < tpa_pkg::NUM_CHAN; c++) begin : g_lane
		logic [tpa_pkg::PIX_W-1:0] ref_q;
		logic [tpa_pkg::SUM_W-1:0] sum_q;
		logic [tpa_pkg::CNT_W-1:0] cnt_q;
		logic [tpa_pkg::SUM_W-1:0] sum_d;
		logic [tpa_pkg::CNT_W-1:0] cnt_d;
		logic [tpa_pkg::PIX_W-1:0] diff;
		logic admit;

		logic [tpa_pkg::CNT_W-1:0] rem_q;
		logic [tpa_pkg::SUM_W-1:0] quo_q;
		logic [tpa_pkg::CNT_W-1:0] dvs_q;
		logic [tpa_pkg::CNT_W:0] shifted;
		logic fits;
		logic [tpa_pkg::CNT_W:0] twice_r;
		logic round_up;
		logic [tpa_pkg::PIX_W-1:0] res_q;

		always_comb begin
			diff = (px[c] >= ref_q) ? (px[c] - ref_q) : (ref_q - px[c]);
			admit = take && (diff <= tau_q);
			if (kind == tpa_pkg::KIND_REF) begin
				sum_d = tpa_pkg::SUM_W'(px[c]);
				cnt_d = tpa_pkg::CNT_W'(1);
			end else if (admit) begin
				sum_d = sum_q + tpa_pkg::SUM_W'(px[c]);
				cnt_d = cnt_q + tpa_pkg::CNT_W'(1);
			end else begin
				sum_d = sum_q;
				cnt_d = cnt_q;
			end
		end

		// Restoring division, one quotient bit per cycle, MSB first.
		assign shifted = {rem_q, quo_q[tpa_pkg::SUM_W-1]};
		assign fits = (shifted >= {1'b0, dvs_q});

		// Round half to even from the final quotient and remainder.
		assign twice_r = {rem_q, 1'b0};
		assign round_up = (twice_r > {1'b0, dvs_q}) ||
			((twice_r == {1'b0, dvs_q}) && quo_q[0]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ref_q <= '0;
				sum_q <= '0;
				cnt_q <= '0;
			end else if (cmd.acc_en) begin
				if (kind == tpa_pkg::KIND_REF) begin
					ref_q <= px[c];
				end
				sum_q <= sum_d;
				cnt_q <= cnt_d;
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.div_load) begin
				rem_q <= '0;
				quo_q <= sum_d;
				dvs_q <= cnt_d;
			end else if (cmd.div_step) begin
				quo_q <= {quo_q[tpa_pkg::SUM_W-2:0], fits};
				if (fits) begin
					rem_q <= tpa_pkg::CNT_W'(shifted - {1'b0, dvs_q});
				end else begin
					rem_q <= shifted[tpa_pkg::CNT_W-1:0];
				end
			end
			if (cmd.res_load) begin
				if (dvs_q == '0) begin
					res_q <= '0;
				end else begin
					res_q <= quo_q[tpa_pkg::PIX_W-1:0] + tpa_pkg::PIX_W'(round_up);
				end
			end
		end

		assign res[c] = res_q;
	end

endmodule

// ----- rtl/thresholded_temporal_pixel_average.sv -----
// Top level of the thresholded temporal pixel average.
// A reference sample opens a pixel and the warped neighbour samples are taken one per
// cycle while the input is not held off; a channel takes the neighbour when it lies
// within the threshold tau written through cfg_wdata of the reference, and at most
// 2*NEIGHBOURS_PER_SIDE neighbours count per pixel. For a sample marked last, the three
// channel averages come from a restoring divider that produces one quotient bit per
// cycle, followed by round-half-to-even into the result register. The input is held off
// during the divide and the rounding step. The result register lets the next pixel
// stream in while a finished result waits downstream, and a second result waits in the
// divider, with the input held off, until the first has gone.
module thresholded_temporal_pixel_average (
	input  logic                      clk,
	input  logic                      arst_n,
	tpa_in_if.sink                    pix_in,
	tpa_out_if.source                 pix_out,
	input  logic                      cfg_we,
	input  logic [tpa_pkg::PIX_W-1:0] cfg_wdata
);

	tpa_pkg::dp_cmd_t cmd;
	tpa_pkg::dp_sts_t sts;
	tpa_pkg::pix_vec_t px;
	tpa_pkg::pix_vec_t res;

	assign px[0] = pix_in.chan_red;
	assign px[1] = pix_in.chan_green;
	assign px[2] = pix_in.chan_blue;

	assign pix_out.out_red = res[0];
	assign pix_out.out_green = res[1];
	assign pix_out.out_blue = res[2];

	tpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_in.valid),
		.in_last   (pix_in.last),
		.in_ready  (pix_in.ready),
		.out_ready (pix_out.ready),
		.out_valid (pix_out.valid),
		.cmd       (cmd),
		.sts       (sts)
	);

	tpa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.kind      (pix_in.kind),
		.px        (px),
		.cmd       (cmd),
		.sts       (sts),
		.res       (res)
	);

endmodule
